// File: src/sorted_record_list_unit_defines.svh
// Assertion macros shared by the sorted record list RTL.
// Used by files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef SORTED_RECORD_LIST_UNIT_DEFINES_SVH
`define SORTED_RECORD_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/srl_pkg.sv
// Package for the sorted record list: payload structs, codes and the key decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srl_pkg;

  localparam int KEY_W       = 14;
  localparam int KEY_DIGITS  = 4;
  localparam int QUEUE_DEPTH = 2;  // power of two, pointers wrap naturally

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_CODE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_RECORD    = 3'd5
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [63:0] code_chars;
    logic [7:0]  credit_count;
    logic [7:0]  grade_char;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] out_code;
    logic [7:0]  out_credits;
    logic [7:0]  out_grade;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
  } key_info_t;

  // Classified command as it travels from the front to the back.
  typedef struct packed {
    action_t          action;
    logic [63:0]      code;
    logic [7:0]       credits;
    logic [7:0]       grade;
    logic [KEY_W-1:0] key;
    logic             key_ok;
  } cmd_t;

  typedef struct packed {
    logic [63:0]      code;
    logic [KEY_W-1:0] key;
    logic [7:0]       credits;
    logic [7:0]       grade;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INS_SCAN,
    BK_INS_PUT,
    BK_DEL_SCAN,
    BK_LIST_SCAN,
    BK_REPLY
  } back_state_t;

  // The key is the run of leading digits from the fifth character on, at most
  // four of them. The first four characters must all be non-zero and the fifth a digit.
  function automatic key_info_t code_key(input logic [63:0] code);
    key_info_t        r;
    logic             run;
    logic [7:0]       c;
    logic [KEY_W-1:0] v;
    r.ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (code[63-8*i -: 8] == 8'h00) begin
        r.ok = 1'b0;
      end
    end
    if (!(code[31:24] inside {[8'h30:8'h39]})) begin
      r.ok = 1'b0;
    end
    run = 1'b1;
    v   = '0;
    for (int i = 0; i < KEY_DIGITS; i++) begin
      c = code[31-8*i -: 8];
      if (run && (c inside {[8'h30:8'h39]})) begin
        v = KEY_W'(v * KEY_W'(10)) + KEY_W'(c - 8'h30);
      end else begin
        run = 1'b0;
      end
    end
    r.key = v;
    return r;
  endfunction

endpackage

// File: src/srl_front.sv
// Front end of the sorted record list: takes input transactions and classifies them.
// Depends on srl_pkg; feeds srl_queue.
`timescale 1ns / 1ps

module srl_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  srl_pkg::in_item_t in_data,
  input  logic            q_full,
  output logic            q_push,
  output srl_pkg::cmd_t   q_data
);
  import srl_pkg::*;

  key_info_t kinfo;

  assign kinfo    = code_key(in_data.code_chars);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.action  = in_data.action;
    q_data.code    = in_data.code_chars;
    q_data.credits = in_data.credit_count;
    q_data.grade   = in_data.grade_char;
    q_data.key     = kinfo.key;
    q_data.key_ok  = kinfo.ok;
  end

endmodule

// File: src/srl_queue.sv
// Short command queue between the front and back of the sorted record list.
// Depends on srl_pkg for the command type and depth.
`timescale 1ns / 1ps

module srl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  srl_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output srl_pkg::cmd_t pop_data,
  output logic          not_empty
);
  import srl_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;

  assign full      = (fill_r == QCW'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/srl_back.sv
// Back end of the sorted record list: record memory, scan sequencer and result register.
// Depends on srl_pkg and the assertion macros in sorted_record_list_unit_defines.svh.
`timescale 1ns / 1ps
`include "sorted_record_list_unit_defines.svh"

module srl_back #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  srl_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output srl_pkg::out_item_t out_data
);
  import srl_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t      mem [DEPTH];
  entry_t      rd_data_r;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic        rd_more_r, rd_more_nxt;
  logic        pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic        found_r, found_nxt;
  status_t     reply_r, reply_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        rd_en;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  entry_t      wr_data;
  entry_t      new_entry;
  logic        out_free;
  logic        consume;
  logic        finish;
  logic        code_hit;
  logic [IW-1:0] last_idx;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_idx  = IW'(count_r - CW'(1));
  assign code_hit  = (rd_data_r.code == cmd_r.code);

  always_comb begin
    new_entry.code    = cmd_r.code;
    new_entry.key     = cmd_r.key;
    new_entry.credits = cmd_r.credits;
    new_entry.grade   = cmd_r.grade;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_more_nxt   = rd_more_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    reply_nxt     = reply_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data_r;
    consume       = 1'b0;
    finish        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          case (q_data.action)
            ACT_INSERT: begin
              if (!q_data.key_ok) begin
                reply_nxt = ST_BAD_CODE;
                state_nxt = BK_REPLY;
              end else if (count_r == CW'(DEPTH)) begin
                reply_nxt = ST_FULL;
                state_nxt = BK_REPLY;
              end else if (count_r == '0) begin
                state_nxt = BK_INS_PUT;
              end else begin
                rd_idx_nxt  = last_idx;
                rd_more_nxt = 1'b1;
                state_nxt   = BK_INS_SCAN;
              end
            end
            ACT_DELETE: begin
              if (count_r == '0) begin
                reply_nxt = ST_NOT_FOUND;
                state_nxt = BK_REPLY;
              end else begin
                rd_idx_nxt  = '0;
                rd_more_nxt = 1'b1;
                state_nxt   = BK_DEL_SCAN;
              end
            end
            ACT_CLEAR: begin
              count_nxt = '0;
              reply_nxt = ST_DONE;
              state_nxt = BK_REPLY;
            end
            ACT_LIST: begin
              if (count_r == '0) begin
                reply_nxt = ST_EMPTY;
                state_nxt = BK_REPLY;
              end else begin
                rd_idx_nxt  = '0;
                rd_more_nxt = 1'b1;
                state_nxt   = BK_LIST_SCAN;
              end
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end

      // Walk down from the top entry, moving each larger-or-equal key up one
      // place, until the insertion point is reached.
      BK_INS_SCAN: begin
        if (pend_r) begin
          consume = 1'b1;
          wr_en   = 1'b1;
          wr_addr = pend_idx_r + 1'b1;
          if (rd_data_r.key < cmd_r.key) begin
            wr_data   = new_entry;
            finish    = 1'b1;
            count_nxt = count_r + 1'b1;
            reply_nxt = ST_DONE;
            state_nxt = BK_REPLY;
          end else if (pend_idx_r == '0) begin
            finish    = 1'b1;
            state_nxt = BK_INS_PUT;
          end
        end
      end

      BK_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_entry;
        count_nxt = count_r + 1'b1;
        reply_nxt = ST_DONE;
        state_nxt = BK_REPLY;
      end

      // Once the matching code has been seen, every later entry moves down one.
      BK_DEL_SCAN: begin
        if (pend_r) begin
          consume = 1'b1;
          if (found_r) begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_r - 1'b1;
          end else if (code_hit) begin
            found_nxt = 1'b1;
          end
          if (pend_idx_r == last_idx) begin
            finish    = 1'b1;
            state_nxt = BK_REPLY;
            if (found_r || code_hit) begin
              count_nxt = count_r - 1'b1;
              reply_nxt = ST_DONE;
            end else begin
              reply_nxt = ST_NOT_FOUND;
            end
          end
        end
      end

      BK_LIST_SCAN: begin
        if (pend_r && out_free) begin
          consume                  = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_RECORD;
          out_data_nxt.out_code    = rd_data_r.code;
          out_data_nxt.out_credits = rd_data_r.credits;
          out_data_nxt.out_grade   = rd_data_r.grade;
          out_data_nxt.last_result = (pend_idx_r == last_idx);
          if (pend_idx_r == last_idx) begin
            finish    = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end

      BK_REPLY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = reply_r;
          out_data_nxt.out_code    = '0;
          out_data_nxt.out_credits = '0;
          out_data_nxt.out_grade   = '0;
          out_data_nxt.last_result = 1'b1;
          state_nxt                = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Read issue: a new read goes out when the registered read data is free
    // or is being used this cycle.
    rd_en = rd_more_r && (!pend_r || consume) && !finish;
    if (finish) begin
      rd_more_nxt = 1'b0;
      pend_nxt    = 1'b0;
    end else begin
      if (consume) begin
        pend_nxt = 1'b0;
      end
      if (rd_en) begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = rd_idx_r;
        if (state_r == BK_INS_SCAN) begin
          if (rd_idx_r == '0) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end else begin
          if (rd_idx_r == last_idx) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      rd_more_r   <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_more_r   <= rd_more_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    reply_r    <= reply_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  `SRL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "record count above depth")
  `SRL_ASSERT_NOW(a_pend_in_scan, pend_r,
    state_r == BK_INS_SCAN || state_r == BK_DEL_SCAN || state_r == BK_LIST_SCAN,
    "read data pending outside a scan")
  `SRL_ASSERT_NEXT(a_clear_empties, state_r == BK_IDLE && q_pop && q_data.action == ACT_CLEAR,
    count_r == '0, "clear did not empty the table")
  `SRL_ASSERT_NOW(a_write_in_range, wr_en, wr_addr < IW'(DEPTH - 1) || wr_addr == IW'(DEPTH - 1),
    "record write beyond the table")

endmodule

// File: src/sorted_record_list_unit.sv
// Sorted record list: an ordered table of up to DEPTH records keyed by code digits.
// Channels: in_valid/in_stall/in_data carry one command per transaction (insert,
// delete, clear, list); out_valid/out_stall/out_data return its results. Insert,
// delete and clear give one result; list gives one result per record, or one
// empty result, with last_result set on the final one.
// A two-entry command queue lets the front keep taking transactions while the
// back works; in_stall rises only when that queue is full.
// The record memory has one read and one write port and is walked one entry per
// cycle, except that a list scan pauses while the output is stalled.
// Results appear in a registered output stage; while out_stall is high the
// result holds and the back pauses a list scan, losing nothing.
// Reset empties the table and the queue at once; no clearing pass is needed.
// Depends on srl_pkg, srl_front, srl_queue and srl_back.
`timescale 1ns / 1ps

module sorted_record_list_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  srl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output srl_pkg::out_item_t out_data
);
  import srl_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  cmd_t q_out;
  logic q_not_empty;

  srl_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  srl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  srl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: dv/sorted_record_list_unit_tb.sv
// Self-checking testbench for sorted_record_list_unit: directed and random commands
// checked against a behavioural model of the ordered record table kept in this file.
// Depends on srl_pkg and the sorted_record_list_unit RTL.
`timescale 1ns / 1ps

module sorted_record_list_unit_tb;
  import srl_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sorted_record_list_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Model of the record table.
  logic [63:0]      table_codes   [DEPTH];
  logic [KEY_W-1:0] table_keys    [DEPTH];
  logic [7:0]       table_credits [DEPTH];
  logic [7:0]       table_grades  [DEPTH];
  int               table_count = 0;

  in_item_t    pending_cmds[$];
  out_item_t   expected_results[$];
  logic [63:0] known_codes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  logic hold_start   = 1'b0;

  // The key is the run of digits starting at the fifth character, at most four.
  function automatic logic key_from_code(input logic [63:0] code,
                                         output logic [KEY_W-1:0] key);
    logic [7:0] ch [8];
    int digits;
    logic ok;
    for (int i = 0; i < 8; i++) ch[i] = code[63-8*i -: 8];
    ok     = (ch[0] != 8'h00) && (ch[1] != 8'h00) && (ch[2] != 8'h00) && (ch[3] != 8'h00);
    key    = '0;
    digits = 0;
    for (int i = 4; i < 8; i++) begin
      if (digits == i - 4 && ch[i] >= 8'h30 && ch[i] <= 8'h39) begin
        key    = KEY_W'(key * 10 + (ch[i] - 8'h30));
        digits = digits + 1;
      end
    end
    return ok && (digits != 0);
  endfunction

  task automatic predict_command(input in_item_t cmd);
    logic [KEY_W-1:0] key;
    logic ok;
    int pos;
    out_item_t r;
    r = '0;
    r.last_result = 1'b1;
    case (cmd.action)
      ACT_INSERT: begin
        ok = key_from_code(cmd.code_chars, key);
        if (!ok) begin
          r.status = ST_BAD_CODE;
        end else if (table_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < table_count && table_keys[pos] < key) pos++;
          for (int i = table_count; i > pos; i--) begin
            table_codes[i]   = table_codes[i-1];
            table_keys[i]    = table_keys[i-1];
            table_credits[i] = table_credits[i-1];
            table_grades[i]  = table_grades[i-1];
          end
          table_codes[pos]   = cmd.code_chars;
          table_keys[pos]    = key;
          table_credits[pos] = cmd.credit_count;
          table_grades[pos]  = cmd.grade_char;
          table_count++;
          r.status = ST_DONE;
        end
        expected_results.push_back(r);
      end
      ACT_DELETE: begin
        pos = 0;
        while (pos < table_count && table_codes[pos] !== cmd.code_chars) pos++;
        if (pos >= table_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < table_count; i++) begin
            table_codes[i]   = table_codes[i+1];
            table_keys[i]    = table_keys[i+1];
            table_credits[i] = table_credits[i+1];
            table_grades[i]  = table_grades[i+1];
          end
          table_count--;
          r.status = ST_DONE;
        end
        expected_results.push_back(r);
      end
      ACT_CLEAR: begin
        table_count = 0;
        r.status    = ST_DONE;
        expected_results.push_back(r);
      end
      default: begin
        if (table_count == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < table_count; i++) begin
            r.status      = ST_RECORD;
            r.out_code    = table_codes[i];
            r.out_credits = table_credits[i];
            r.out_grade   = table_grades[i];
            r.last_result = (i + 1 == table_count);
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    logic ok;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: status %0d code %h credits %0d grade %0d last %0b",
                 got.status, got.out_code, got.out_credits, got.out_grade, got.last_result);
    end else begin
      want = expected_results.pop_front();
      ok   = (got.status === want.status) && (got.out_code === want.out_code) &&
             (got.out_credits === want.out_credits) && (got.out_grade === want.out_grade) &&
             (got.last_result === want.last_result);
      if (!ok) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result mismatch at cycle %0d", cycle_count);
          $display("  expected status %0d code %h credits %0d grade %0d last %0b",
                   want.status, want.out_code, want.out_credits, want.out_grade,
                   want.last_result);
          $display("  actual   status %0d code %h credits %0d grade %0d last %0b",
                   got.status, got.out_code, got.out_credits, got.out_grade,
                   got.last_result);
        end
      end
    end
  endtask

  // Driver: a new transaction is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_command(in_data);
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] code_from(input string s);
    logic [63:0] c;
    c = '0;
    for (int i = 0; i < s.len() && i < 8; i++) c[63-8*i -: 8] = s[i];
    return c;
  endfunction

  function automatic in_item_t make_cmd(input action_t act, input logic [63:0] code,
                                        input logic [7:0] credits, input logic [7:0] grade);
    in_item_t c;
    c.action       = act;
    c.code_chars   = code;
    c.credit_count = credits;
    c.grade_char   = grade;
    return c;
  endfunction

  function automatic logic [63:0] wellformed_code();
    logic [63:0] c;
    int k;
    for (int i = 0; i < 4; i++)
      c[63-8*i -: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(8'h41, 8'h5A));
    c[31:24] = 8'(8'h30 + $urandom_range(9));
    for (int i = 5; i < 8; i++) begin
      k = $urandom_range(9);
      if (k < 6) c[63-8*i -: 8] = 8'(8'h30 + $urandom_range(9));
      else if (k < 8) c[63-8*i -: 8] = 8'h00;
      else c[63-8*i -: 8] = 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    int pick;
    int sel;
    c.code_chars   = {$urandom, $urandom};
    c.credit_count = 8'($urandom);
    c.grade_char   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      c.action = ACT_INSERT;
      sel = $urandom_range(99);
      if (sel < 80) begin
        c.code_chars = wellformed_code();
        known_codes.push_back(c.code_chars);
        if (known_codes.size() > 24) void'(known_codes.pop_front());
      end else if (sel < 90) begin
        c.code_chars = wellformed_code();
        if ($urandom_range(1) == 0) begin
          c.code_chars[63-8*$urandom_range(3) -: 8] = 8'h00;
        end else begin
          case ($urandom_range(3))
            0: c.code_chars[31:24] = 8'h2F;
            1: c.code_chars[31:24] = 8'h3A;
            2: c.code_chars[31:24] = 8'h00;
            default: c.code_chars[31:24] = 8'($urandom_range(8'h3A, 8'hFF));
          endcase
        end
      end
    end else if (pick < 75) begin
      c.action = ACT_DELETE;
      sel = $urandom_range(99);
      if (known_codes.size() != 0 && sel < 70) begin
        c.code_chars = known_codes[$urandom_range(known_codes.size() - 1)];
      end else if (known_codes.size() != 0 && sel < 85) begin
        c.code_chars = known_codes[$urandom_range(known_codes.size() - 1)] ^
                       (64'd1 << $urandom_range(63));
      end
    end else if (pick < 78) begin
      c.action = ACT_CLEAR;
    end else begin
      c.action = ACT_LIST;
    end
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) pending_cmds.push_back(random_command());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, rejected codes, a fill up to capacity, then list, delete and clear.
    pending_cmds.push_back(make_cmd(ACT_LIST,   '0, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_DELETE, code_from("ABCD0"), 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_CLEAR,  '0, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 64'h00424344_31000000, 8'd1, 8'h41));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 64'h41424300_35000000, 8'd1, 8'h41));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("ABCD:1"), 8'd1, 8'h41));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("ABCD/1"), 8'd1, 8'h41));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("ABCD0"), 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("ABCD9999"), 8'd255, 8'd255));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("ZZZZ0042"), 8'd3, 8'h42));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("ZZZZ42"), 8'd4, 8'h43));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("QRST42X7"), 8'd5, 8'h44));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("MMMM5"), 8'd6, 8'h45));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("MMMM05"), 8'd7, 8'h46));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("AAAA1234"), 8'd8, 8'h41));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("BBBB0001"), 8'd9, 8'h42));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("CCCC9"), 8'd10, 8'h43));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 64'hFFFFFFFF_37FFFFFF, 8'd255, 8'hFF));
    // A zero byte ends the digit run even when a digit follows it.
    pending_cmds.push_back(make_cmd(ACT_INSERT, 64'h45454545_33003900, 8'd11, 8'h44));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("FFFF0000"), 8'd12, 8'h45));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("GGGG8888"), 8'd13, 8'h46));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("HHHH777"), 8'd14, 8'h41));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("IIII66"), 8'd15, 8'h42));
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("JJJJ1"), 8'd16, 8'h43));
    // A bad code is reported ahead of a full table.
    pending_cmds.push_back(make_cmd(ACT_INSERT, code_from("JJJJX1"), 8'd16, 8'h43));
    pending_cmds.push_back(make_cmd(ACT_LIST,   '0, 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_DELETE, code_from("ZZZZ42"), 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_DELETE, code_from("ZZZZ43"), 8'd0, 8'd0));
    pending_cmds.push_back(make_cmd(ACT_CLEAR,  '0, 8'd0, 8'd0));
    wait_drained();

    // Random commands with no idling, under a long receiver hold-off.
    for (int i = 0; i < 38; i++) pending_cmds.push_back(random_command());
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_drained();

    run_phase(38, 88, 0);
    run_phase(38, 0, 88);
    run_phase(38, 30, 30);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/srl_pkg.sv
src/srl_front.sv
src/srl_queue.sv
src/srl_back.sv
src/sorted_record_list_unit.sv
dv/sorted_record_list_unit_tb.sv
